// ===== hdl/utf8u_pkg.sv =====
// Package for the UTF-8 to UCS-2 stream decoder.
// Holds the count width, lead-byte codes, masks and the result word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8u_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned UnitBits  = 16;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned RemBits   = 3;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [UnitBits-1:0]  CapReset = 16'hFFFF;

  // lead-byte thresholds, longest form first
  localparam logic [ByteBits-1:0] Lead6 = 8'hFC;
  localparam logic [ByteBits-1:0] Lead5 = 8'hF8;
  localparam logic [ByteBits-1:0] Lead4 = 8'hF0;
  localparam logic [ByteBits-1:0] Lead3 = 8'hE0;
  localparam logic [ByteBits-1:0] Lead2 = 8'hC0;

  localparam logic [ByteBits-1:0] Mask6    = 8'h01;
  localparam logic [ByteBits-1:0] Mask5    = 8'h03;
  localparam logic [ByteBits-1:0] Mask4    = 8'h07;
  localparam logic [ByteBits-1:0] Mask3    = 8'h0F;
  localparam logic [ByteBits-1:0] Mask2    = 8'h1F;
  localparam logic [ByteBits-1:0] ContMask = 8'h3F;

  localparam logic [ByteBits-1:0] NulByte = 8'h00;

  typedef struct packed {
    logic [CountBits-1:0] units_written;
    logic                 full_res;
    logic                 string_end;
    logic                 unit_valid;
    logic [UnitBits-1:0]  unit;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/utf8u_decode.sv =====
// Decoder state and per-byte next-state / result logic.
// Depends on utf8u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8u_decode (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [utf8u_pkg::ByteBits-1:0]       byte_i,
  input  wire logic [utf8u_pkg::UnitBits-1:0]       capacity_i,
  output utf8u_pkg::res_t                           res_o,
  output logic                                      res_valid_o
);

  // only the low 16 bits of the code point ever reach the output
  logic [utf8u_pkg::UnitBits-1:0]  acc_q, acc_d;
  logic [utf8u_pkg::RemBits-1:0]   rem_q, rem_d;
  logic [utf8u_pkg::CountBits-1:0] count_q, count_d;
  logic                            full_q, full_d;

  logic [utf8u_pkg::UnitBits-1:0]  cp;
  logic [utf8u_pkg::RemBits-1:0]   rem_dec;
  logic                            finish;

  always_comb begin
    acc_d       = acc_q;
    rem_d       = rem_q;
    count_d     = count_q;
    full_d      = full_q;
    cp          = acc_q;
    finish      = 1'b0;
    rem_dec     = rem_q - utf8u_pkg::RemBits'(1);
    res_o       = '0;
    res_valid_o = 1'b0;

    if (rem_q != '0) begin
      cp     = {acc_q[utf8u_pkg::UnitBits-7:0], byte_i[5:0]};
      acc_d  = cp;
      rem_d  = rem_dec;
      finish = (rem_dec == '0);
    end else if (byte_i == utf8u_pkg::NulByte) begin
      res_valid_o         = 1'b1;
      res_o.string_end    = 1'b1;
      res_o.full_res      = full_q;
      res_o.units_written = count_q;
      count_d             = '0;
      full_d              = 1'b0;
      acc_d               = '0;
    end else if (byte_i >= utf8u_pkg::Lead6) begin
      acc_d = {8'h00, byte_i & utf8u_pkg::Mask6};
      rem_d = 3'd5;
    end else if (byte_i >= utf8u_pkg::Lead5) begin
      acc_d = {8'h00, byte_i & utf8u_pkg::Mask5};
      rem_d = 3'd4;
    end else if (byte_i >= utf8u_pkg::Lead4) begin
      acc_d = {8'h00, byte_i & utf8u_pkg::Mask4};
      rem_d = 3'd3;
    end else if (byte_i >= utf8u_pkg::Lead3) begin
      acc_d = {8'h00, byte_i & utf8u_pkg::Mask3};
      rem_d = 3'd2;
    end else if (byte_i >= utf8u_pkg::Lead2) begin
      acc_d = {8'h00, byte_i & utf8u_pkg::Mask2};
      rem_d = 3'd1;
    end else begin
      // single-byte code, 0x80-0xBF included
      cp     = {8'h00, byte_i};
      finish = 1'b1;
    end

    if (finish) begin
      acc_d = '0;
      if (!full_q) begin
        res_valid_o = 1'b1;
        if ((count_q >= capacity_i) || (count_q == utf8u_pkg::CountMax)) begin
          full_d              = 1'b1;
          res_o.full_res      = 1'b1;
          res_o.units_written = count_q;
        end else begin
          count_d             = count_q + utf8u_pkg::CountBits'(1);
          res_o.unit          = {cp[7:0], cp[15:8]};
          res_o.unit_valid    = 1'b1;
          res_o.units_written = count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      rem_q   <= '0;
      count_q <= '0;
      full_q  <= 1'b0;
    end else if (step_i) begin
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      count_q <= count_d;
      full_q  <= full_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8_to_ucs2_stream_decoder.sv =====
// Top level of the UTF-8 to UCS-2 stream decoder: input register, capacity
// register, output register. Depends on utf8u_pkg and utf8u_decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes one UTF-8 byte per cycle while m_axis does not stall, and emits a word
// per finished character, for the first character dropped once full, and per
// NUL that ends a string. A byte entering at s_axis passes the input register,
// the decoder logic and the output register before it shows on m_axis; the
// decoder state updates between the input register and the output register.
// Bytes that only start or continue a character produce no output word.
module utf8_to_ucs2_stream_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [utf8u_pkg::UnitBits-1:0]    cfg_wdata_i,   // capacity
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // data_byte
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [31:0]                            m_axis_tdata,  // unit, units_written
  output logic [2:0]                             m_axis_tuser   // unit_valid, string_end, full_res
);

  logic                           in_valid_q;
  logic [utf8u_pkg::ByteBits-1:0] in_byte_q;
  logic [utf8u_pkg::UnitBits-1:0] capacity_q;
  logic                           out_valid_q;
  utf8u_pkg::res_t                out_q;

  utf8u_pkg::res_t res;
  logic            res_valid;
  logic            advance;
  logic            out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  utf8u_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .capacity_i  (capacity_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= utf8u_pkg::CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.units_written, out_q.unit};
  assign m_axis_tuser  = {out_q.full_res, out_q.string_end, out_q.unit_valid};

  // a written unit always carries a nonzero count
  a_unit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.unit_valid) |-> (out_q.units_written != '0))
    else $error("unit word with zero count");

  // a string end never carries a unit
  a_end_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.string_end) |-> (!out_q.unit_valid && out_q.unit == '0))
    else $error("string end carries a unit");

  // a full word is never a written unit
  a_full_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.full_res) |-> !out_q.unit_valid)
    else $error("full word flagged as written unit");

endmodule

`default_nettype wire
